FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while reset is high.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Clocked implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Types, constants and register codes of the tile map fetch and collide block.
// ----------------------------------------------------------------------------
package tmq_pkg;

   localparam int MapDepthDefault = 4096;
   localparam int CellW = 16;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_RENDER  = 2'd2,
      ACT_COLLIDE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_TILE_W   = 3'd0,
      REG_TILE_H   = 3'd1,
      REG_MAP_W    = 3'd2,
      REG_MAP_H    = 3'd3,
      REG_WIDE     = 3'd4,
      REG_PRESENT  = 3'd5,
      REG_GRID_COL = 3'd6,
      REG_SPARE    = 3'd7
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_ADDR,
      ST_MUL,
      ST_LOOK,
      ST_WAIT,
      ST_DATA,
      ST_CONTACT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        cell_value;
      logic signed [15:0] scroll_x;
      logic signed [15:0] scroll_y;
      logic [9:0]         grid_col;
      logic [9:0]         grid_row;
      logic [1:0]         side;
      logic signed [15:0] move_x;
      logic signed [15:0] move_y;
   } req_type;

   typedef struct packed {
      logic [15:0]        vertex_index;
      logic [15:0]        texcoord_index;
      logic [15:0]        tile_value;
      logic signed [15:0] contact;
      logic               hit;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tile_w;
      logic [7:0]  tile_h;
      logic [12:0] map_w;
      logic [12:0] map_h;
      logic        wide;
      logic        present;
      logic [10:0] grid_cols;
   } cfg_type;

   // Divider handshake between sequencer and divider.
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [7:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/tmq_ram.sv
// ----------------------------------------------------------------------------
// tmq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tmq_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tmq_div.sv
// ----------------------------------------------------------------------------
// tmq_div
// Restoring divider: 17-bit unsigned dividend by 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module tmq_div (
   input  logic                     clock,
   input  logic                     reset,
   input  tmq_pkg::div_req_type     div_req,
   output tmq_pkg::div_rsp_type     div_rsp
);

   logic [16:0] quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[7:0], quo_ff[16]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/tmq_seq.sv
// ----------------------------------------------------------------------------
// tmq_seq
// Per-transaction sequencer: divisions, bounds, address, map read or write, result emit.
// ----------------------------------------------------------------------------
module tmq_seq #(
   parameter int MapDepth = tmq_pkg::MapDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmq_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tmq_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tmq_pkg::rsp_type            rsp_data,
   output tmq_pkg::div_req_type        div_req,
   input  tmq_pkg::div_rsp_type        div_rsp,
   output logic                        mem_wr,
   output logic [$clog2(MapDepth)-1:0] mem_addr,
   output logic [15:0]                 mem_wdata,
   input  logic [15:0]                 mem_rdata
);

   localparam int AW = $clog2(MapDepth);

   tmq_pkg::state_type st_ff, st_in;
   tmq_pkg::req_type   rq_ff, rq_in;
   tmq_pkg::rsp_type   out_ff, out_in;
   logic               ov_ff, ov_in;
   logic [1:0]         k_ff, k_in;
   logic signed [17:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [25:0]        prod_ff, prod_in;
   logic [17:0]        cbase_ff, cbase_in;
   logic               ok_ff, ok_in;
   logic [15:0]        tile_ff, tile_in;
   logic [15:0]        vi_ff, vi_in;
   logic [15:0]        ti_ff, ti_in;
   logic [1:0]         nres_ff, nres_in;

   logic [7:0]         tw, th;
   logic signed [16:0] qx, qy;
   logic [16:0]        absx, absy;
   logic [15:0]        rd_cell;
   logic [20:0]        limx, limy;
   logic               accept;

   assign tw = (cfg.tile_w == 8'd0) ? 8'd1 : cfg.tile_w;
   assign th = (cfg.tile_h == 8'd0) ? 8'd1 : cfg.tile_h;
   assign qx = 17'(rq_ff.pos_x) + 17'(rq_ff.move_x);
   assign qy = 17'(rq_ff.pos_y) + 17'(rq_ff.move_y);
   assign absx = rq_ff.scroll_x[15] ? 17'(-17'(rq_ff.scroll_x)) : 17'(rq_ff.scroll_x);
   assign absy = rq_ff.scroll_y[15] ? 17'(-17'(rq_ff.scroll_y)) : 17'(rq_ff.scroll_y);
   assign rd_cell = cfg.wide ? mem_rdata : {8'd0, mem_rdata[7:0]};
   assign limx = 21'(tw) * 21'(cfg.map_w);
   assign limy = 21'(th) * 21'(cfg.map_h);
   assign accept = req_valid && !req_stall;
   assign req_stall = (st_ff != tmq_pkg::ST_IDLE) || ov_ff;

   always_comb begin
      st_in    = st_ff;
      rq_in    = rq_ff;
      out_in   = out_ff;
      ov_in    = ov_ff;
      k_in     = k_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      prod_in  = prod_ff;
      cbase_in = cbase_ff;
      ok_in    = ok_ff;
      tile_in  = tile_ff;
      vi_in    = vi_ff;
      ti_in    = ti_ff;
      nres_in  = nres_ff;
      div_req  = '0;
      mem_wr   = 1'b0;
      mem_addr = prod_ff[AW-1:0];
      mem_wdata = cfg.wide ? rq_ff.cell_value : {8'd0, rq_ff.cell_value[7:0]};

      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      case (st_ff)
         tmq_pkg::ST_IDLE: begin
            if (accept) begin
               rq_in = req_data;
               cx_in = 18'(req_data.pos_x);
               cy_in = 18'(req_data.pos_y);
               case (req_data.action)
                  tmq_pkg::ACT_RENDER:  st_in = tmq_pkg::ST_DIVX;
                  tmq_pkg::ACT_COLLIDE: st_in = tmq_pkg::ST_DIVX;
                  default:              st_in = tmq_pkg::ST_ADDR;
               endcase
               div_req.start = 1'b0;
            end
         end
         tmq_pkg::ST_DIVX: begin
            // launch x division once, wait for done
            if (!div_rsp.done && k_ff == 2'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = (rq_ff.action == tmq_pkg::ACT_RENDER) ? absx
                                                                         : 17'(qx);
               div_req.divisor  = tw;
               k_in = 2'd1;
            end else if (div_rsp.done) begin
               if (rq_ff.action == tmq_pkg::ACT_RENDER) begin
                  cx_in = (rq_ff.scroll_x[15] ? -18'(div_rsp.quotient)
                                              : 18'(div_rsp.quotient))
                          + 18'(rq_ff.grid_col);
               end else begin
                  cx_in = 18'(div_rsp.quotient);
               end
               k_in  = 2'd0;
               st_in = tmq_pkg::ST_DIVY;
            end
         end
         tmq_pkg::ST_DIVY: begin
            if (!div_rsp.done && k_ff == 2'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = (rq_ff.action == tmq_pkg::ACT_RENDER) ? absy
                                                                         : 17'(qy);
               div_req.divisor  = th;
               k_in = 2'd1;
            end else if (div_rsp.done) begin
               if (rq_ff.action == tmq_pkg::ACT_RENDER) begin
                  cy_in = (rq_ff.scroll_y[15] ? -18'(div_rsp.quotient)
                                              : 18'(div_rsp.quotient))
                          + 18'(rq_ff.grid_row);
               end else begin
                  cy_in = 18'(div_rsp.quotient);
               end
               k_in  = 2'd0;
               st_in = tmq_pkg::ST_ADDR;
            end
         end
         tmq_pkg::ST_ADDR: begin
            ok_in = !cx_ff[17] && !cy_ff[17] && (cx_ff < 18'(cfg.map_w))
                    && (cy_ff < 18'(cfg.map_h));
            if (rq_ff.action == tmq_pkg::ACT_COLLIDE) begin
               ok_in = !qx[16] && !qy[16] && (21'(qx) < limx) && (21'(qy) < limy);
            end
            if (rq_ff.action == tmq_pkg::ACT_RENDER
                && (12'(rq_ff.grid_col) + 12'd1 >= 12'(cfg.grid_cols))) begin
               ok_in = 1'b0;
            end
            st_in = tmq_pkg::ST_MUL;
         end
         tmq_pkg::ST_MUL: begin
            prod_in = 26'(cx_ff[12:0]) + 26'(cfg.map_w) * 26'(cy_ff[12:0]);
            vi_in   = 16'(rq_ff.grid_col) + 16'(cfg.grid_cols) * 16'(rq_ff.grid_row);
            cbase_in = (rq_ff.side[1] ? 18'(cy_ff[12:0]) : 18'(cx_ff[12:0]))
                       + (rq_ff.side[0] ? 18'd0 : 18'd1);
            st_in = tmq_pkg::ST_LOOK;
         end
         tmq_pkg::ST_LOOK: begin
            if (prod_ff >= 26'(MapDepth)) begin
               ok_in = 1'b0;
            end
            st_in = tmq_pkg::ST_WAIT;
         end
         tmq_pkg::ST_WAIT: begin
            // address is stable, RAM data arrives next cycle
            if (rq_ff.action == tmq_pkg::ACT_WRITE) begin
               mem_wr = ok_ff;
               st_in  = tmq_pkg::ST_IDLE;
            end else begin
               st_in = tmq_pkg::ST_DATA;
            end
         end
         tmq_pkg::ST_DATA: begin
            tile_in = ok_ff ? rd_cell : 16'd0;
            st_in   = tmq_pkg::ST_CONTACT;
            k_in    = 2'd0;
         end
         tmq_pkg::ST_CONTACT: begin
            prod_in = 26'(rq_ff.side[1] ? th : tw) * 26'(cbase_ff);
            ti_in   = cfg.present ? 16'((tile_ff - 16'd1) << 2) : 16'd0;
            nres_in = 2'd0;
            case (rq_ff.action)
               tmq_pkg::ACT_RENDER: begin
                  if (!ok_ff || (cfg.present && tile_ff == 16'd0)) begin
                     st_in = tmq_pkg::ST_IDLE;
                  end else begin
                     nres_in = 2'd3;
                     st_in   = tmq_pkg::ST_EMIT;
                  end
               end
               default: st_in = tmq_pkg::ST_EMIT;
            endcase
         end
         tmq_pkg::ST_EMIT: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in  = 1'b1;
               out_in = '0;
               case (rq_ff.action)
                  tmq_pkg::ACT_READ: begin
                     out_in.tile_value = tile_ff;
                     out_in.last       = 1'b1;
                  end
                  tmq_pkg::ACT_COLLIDE: begin
                     out_in.last = 1'b1;
                     if (tile_ff != 16'd0) begin
                        out_in.hit        = 1'b1;
                        out_in.tile_value = tile_ff;
                        out_in.contact    = 16'(prod_ff[15:0]
                                          - (rq_ff.side[1] ? rq_ff.move_y
                                                           : rq_ff.move_x));
                     end
                  end
                  default: begin
                     case (k_ff)
                        2'd0: out_in.vertex_index = vi_ff;
                        2'd1: out_in.vertex_index = vi_ff + 16'd1;
                        2'd2: out_in.vertex_index = vi_ff + 16'(cfg.grid_cols) + 16'd1;
                        default: out_in.vertex_index = vi_ff + 16'(cfg.grid_cols);
                     endcase
                     out_in.texcoord_index = ti_ff + 16'(k_ff);
                     out_in.last = (k_ff == nres_ff);
                  end
               endcase
               if (rq_ff.action != tmq_pkg::ACT_RENDER || k_ff == nres_ff) begin
                  k_in  = 2'd0;
                  st_in = tmq_pkg::ST_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: st_in = tmq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= tmq_pkg::ST_IDLE;
         ov_ff <= 1'b0;
         k_ff  <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         k_ff  <= k_in;
      end
      rq_ff    <= rq_in;
      out_ff   <= out_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      prod_ff  <= prod_in;
      cbase_ff <= cbase_in;
      ok_ff    <= ok_in;
      tile_ff  <= tile_in;
      vi_ff    <= vi_in;
      ti_ff    <= ti_in;
      nres_ff  <= nres_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: rtl/tile_map_quad_fetch_and_collide_top.sv
// ----------------------------------------------------------------------------
// tile_map_quad_fetch_and_collide_top
// Tile map store with cell read/write, quad index fetch and collision probe.
// ----------------------------------------------------------------------------
// One transaction at a time; the next one is taken once the last result has
// left the output register. A write stores its cell and a read presents its
// result after bounds, address multiply and map access. Render and collide
// first run two bit-serial divisions by the tile size, then bounds, address
// multiply, map read and contact multiply, and then emit their results
// (collide one, render four or none). A stalled consumer holds back the results.
// The map is a single-port RAM with a registered read.
// Map cells are undefined until written.
module tile_map_quad_fetch_and_collide_top #(
   parameter int MapDepth = tmq_pkg::MapDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tmq_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   tmq_pkg::cfg_type     cfg_ff, cfg_in;
   tmq_pkg::div_req_type div_req;
   tmq_pkg::div_rsp_type div_rsp;
   tmq_pkg::reg_type     ridx;
   logic                 mem_wr;
   logic [$clog2(MapDepth)-1:0] mem_addr;
   logic [15:0]          mem_wdata, mem_rdata;

   assign csr_pready = 1'b1;
   assign ridx = tmq_pkg::reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (ridx)
            tmq_pkg::REG_TILE_W:   cfg_in.tile_w    = csr_pwdata[7:0];
            tmq_pkg::REG_TILE_H:   cfg_in.tile_h    = csr_pwdata[7:0];
            tmq_pkg::REG_MAP_W:    cfg_in.map_w     = csr_pwdata[12:0];
            tmq_pkg::REG_MAP_H:    cfg_in.map_h     = csr_pwdata[12:0];
            tmq_pkg::REG_WIDE:     cfg_in.wide      = csr_pwdata[0];
            tmq_pkg::REG_PRESENT:  cfg_in.present   = csr_pwdata[0];
            tmq_pkg::REG_GRID_COL: cfg_in.grid_cols = csr_pwdata[10:0];
            default: ;
         endcase
      end
      case (ridx)
         tmq_pkg::REG_TILE_W:   csr_prdata = 32'(cfg_ff.tile_w);
         tmq_pkg::REG_TILE_H:   csr_prdata = 32'(cfg_ff.tile_h);
         tmq_pkg::REG_MAP_W:    csr_prdata = 32'(cfg_ff.map_w);
         tmq_pkg::REG_MAP_H:    csr_prdata = 32'(cfg_ff.map_h);
         tmq_pkg::REG_WIDE:     csr_prdata = 32'(cfg_ff.wide);
         tmq_pkg::REG_PRESENT:  csr_prdata = 32'(cfg_ff.present);
         tmq_pkg::REG_GRID_COL: csr_prdata = 32'(cfg_ff.grid_cols);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tile_w: 8'd8, tile_h: 8'd8, map_w: 13'd0, map_h: 13'd0,
                    wide: 1'b0, present: 1'b0, grid_cols: 11'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmq_seq #(.MapDepth(MapDepth)) u_seq (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .div_req(div_req), .div_rsp(div_rsp),
      .mem_wr(mem_wr), .mem_addr(mem_addr), .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata)
   );

   tmq_div u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp)
   );

   tmq_ram #(.Width(tmq_pkg::CellW), .Depth(MapDepth)) u_ram (
      .clock(clock), .wr_en(mem_wr), .addr(mem_addr), .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

endmodule

FILE: rtl/tmq_checker.sv
// ----------------------------------------------------------------------------
// tmq_checker
// Port-level checks of the tile map block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tmq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tmq_pkg::rsp_type rsp_data
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `CHK_IMPLY(a_hit_last, clock, reset, rsp_valid && rsp_data.hit, rsp_data.last, "hit result not last")
   `CHK_IMPLY(a_busy, clock, reset, rsp_valid, req_stall, "input taken while result pending")
   `CHK_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "two transactions back to back")
endmodule

bind tile_map_quad_fetch_and_collide_top tmq_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
